FILE: rtl/tbds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbds_pkg
// Shared sizes, register indexes and pixel type of the 2x2 tile box
// downsampler.
// ----------------------------------------------------------------------------
package tbds_pkg;

  localparam int TILE_SIZE = 64;
  localparam int HALF_TILE = TILE_SIZE / 2;
  localparam int EVEN_SPAN = 2 * HALF_TILE;

  // Counter and block-column index widths
  localparam int CNT_W = $clog2(TILE_SIZE);
  localparam int BLK_W = (HALF_TILE > 1) ? $clog2(HALF_TILE) : 1;

  localparam int CH_W   = 16;
  localparam int PAIR_W = CH_W + 1;
  localparam int SUM_W  = CH_W + 2;

  localparam int REG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_TILE_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_TILE_Y = 1'd1;

  localparam int POS_W     = 6;
  localparam int TILE_W    = 15;
  localparam int POS_SUM_W = (CNT_W + 1 > POS_W) ? CNT_W + 1 : POS_W;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_USED_W = 4 * CH_W + 2 * POS_W + 2 * TILE_W;

  typedef struct packed {
    logic [CH_W-1:0] alpha;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [PAIR_W-1:0] alpha;
    logic [PAIR_W-1:0] blue;
    logic [PAIR_W-1:0] green;
    logic [PAIR_W-1:0] red;
  } pair_t;

endpackage

FILE: rtl/tile_box_downsample_2x2_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_box_downsample_2x2_core
// 2x2 box-filter reduction of one square RGBA tile into a destination quadrant.
// ----------------------------------------------------------------------------
// Source pixels of one tile enter in raster order, one per cycle; a result
// is registered from the pixel that closes its 2x2 block and leaves in the
// cycle after it, so the block sustains one pixel per clock while m_tready is
// high. The horizontal pair sums of each even row are kept in a row buffer of
// TILE_SIZE/2 words, read ahead at the even column of the odd row.
// A single output register parts the two sides; s_tready drops only while a
// result waits and m_tready is low. Registers src_tile_x/src_tile_y are
// sampled when each result is formed.
module tile_box_downsample_2x2_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration
  input  logic                                 cfg_we,
  input  logic [tbds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbds_pkg::REG_W-1:0]           cfg_wdata,
  // source pixels
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // in_red, in_green, in_blue, in_alpha
  input  logic [tbds_pkg::IN_DATA_W-1:0]       s_tdata,
  // results
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // out_red, out_green, out_blue, out_alpha, dest_col, dest_row,
  // dest_tile_x, dest_tile_y, zero pad
  output logic [tbds_pkg::OUT_DATA_W-1:0]      m_tdata,
  // last_of_tile
  output logic                                 m_tlast,
  // quadrant_opaque
  output logic                                 m_tuser
);

  localparam int CNT_W = tbds_pkg::CNT_W;
  localparam int BLK_W = tbds_pkg::BLK_W;

  logic [tbds_pkg::REG_W-1:0] src_tile_x;
  logic [tbds_pkg::REG_W-1:0] src_tile_y;

  logic [CNT_W-1:0]       column_count;
  logic [CNT_W-1:0]       row_count;
  logic [CNT_W-1:0]       column_count_next;
  logic [CNT_W-1:0]       row_count_next;
  tbds_pkg::pixel_t       held_left_pixel;
  tbds_pkg::pair_t        pair_above;
  tbds_pkg::pair_t        pair_mem [tbds_pkg::HALF_TILE];
  logic                   alpha_seen;
  logic                   alpha_seen_next;

  tbds_pkg::pixel_t       px;
  tbds_pkg::pair_t        pair_cur;
  tbds_pkg::pixel_t       mean;
  logic [tbds_pkg::SUM_W-1:0] sum_red, sum_green, sum_blue, sum_alpha;
  logic [CNT_W-1:0]       blk_col;
  logic [CNT_W-1:0]       blk_row;
  logic [BLK_W-1:0]       blk_idx;
  logic [tbds_pkg::POS_SUM_W-1:0] pos_col, pos_row;
  logic                   accept, in_span, col_odd, row_odd;
  logic                   make_result, is_last, opaque;
  logic                   col_end, row_end;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign px       = tbds_pkg::pixel_t'(s_tdata);

  assign in_span = ({1'b0, column_count} < (CNT_W+1)'(tbds_pkg::EVEN_SPAN)) &&
                   ({1'b0, row_count} < (CNT_W+1)'(tbds_pkg::EVEN_SPAN));
  assign col_odd = column_count[0];
  assign row_odd = row_count[0];
  assign make_result = accept && in_span && col_odd && row_odd;

  assign blk_col = column_count >> 1;
  assign blk_row = row_count >> 1;
  assign blk_idx = blk_col[BLK_W-1:0];

  always_comb begin
    pair_cur.red   = {1'b0, held_left_pixel.red}   + {1'b0, px.red};
    pair_cur.green = {1'b0, held_left_pixel.green} + {1'b0, px.green};
    pair_cur.blue  = {1'b0, held_left_pixel.blue}  + {1'b0, px.blue};
    pair_cur.alpha = {1'b0, held_left_pixel.alpha} + {1'b0, px.alpha};
    sum_red   = {1'b0, pair_above.red}   + {1'b0, pair_cur.red};
    sum_green = {1'b0, pair_above.green} + {1'b0, pair_cur.green};
    sum_blue  = {1'b0, pair_above.blue}  + {1'b0, pair_cur.blue};
    sum_alpha = {1'b0, pair_above.alpha} + {1'b0, pair_cur.alpha};
    mean.red   = sum_red[tbds_pkg::SUM_W-1:2];
    mean.green = sum_green[tbds_pkg::SUM_W-1:2];
    mean.blue  = sum_blue[tbds_pkg::SUM_W-1:2];
    mean.alpha = sum_alpha[tbds_pkg::SUM_W-1:2];
  end

  assign is_last = (column_count == CNT_W'(tbds_pkg::EVEN_SPAN - 1)) &&
                   (row_count == CNT_W'(tbds_pkg::EVEN_SPAN - 1));
  assign opaque  = is_last && (alpha_seen || (mean.alpha != '0));

  assign pos_col = (src_tile_x[0] ? tbds_pkg::POS_SUM_W'(tbds_pkg::HALF_TILE) : '0) +
                   tbds_pkg::POS_SUM_W'(blk_col);
  assign pos_row = (src_tile_y[0] ? tbds_pkg::POS_SUM_W'(tbds_pkg::HALF_TILE) : '0) +
                   tbds_pkg::POS_SUM_W'(blk_row);

  assign col_end = (column_count == CNT_W'(tbds_pkg::TILE_SIZE - 1));
  assign row_end = (row_count == CNT_W'(tbds_pkg::TILE_SIZE - 1));

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    alpha_seen_next   = alpha_seen;
    if (accept) begin
      if (make_result) begin
        if (is_last) begin
          alpha_seen_next = 1'b0;
        end else if (mean.alpha != '0) begin
          alpha_seen_next = 1'b1;
        end
      end
      if (col_end) begin
        column_count_next = '0;
        if (row_end) begin
          row_count_next  = '0;
          alpha_seen_next = 1'b0;
        end else begin
          row_count_next = row_count + 1'b1;
        end
      end else begin
        column_count_next = column_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_tile_x <= '0;
      src_tile_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tbds_pkg::REG_SRC_TILE_X: src_tile_x <= cfg_wdata;
        tbds_pkg::REG_SRC_TILE_Y: src_tile_y <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count    <= '0;
      row_count       <= '0;
      alpha_seen      <= 1'b0;
      held_left_pixel <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      alpha_seen   <= alpha_seen_next;
      if (accept && in_span && !col_odd) begin
        held_left_pixel <= px;
      end
    end
  end

  // Row buffer: write on the even row, fetch ahead on the odd row's even column
  always_ff @(posedge clk) begin
    if (accept && in_span && col_odd && !row_odd) begin
      pair_mem[blk_idx] <= pair_cur;
    end
    if (accept && in_span && !col_odd && row_odd) begin
      pair_above <= pair_mem[blk_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= make_result;
    end
  end

  always_ff @(posedge clk) begin
    if (make_result) begin
      m_tdata <= {(tbds_pkg::OUT_DATA_W - tbds_pkg::OUT_USED_W)'(0),
                  src_tile_y[tbds_pkg::REG_W-1:1],
                  src_tile_x[tbds_pkg::REG_W-1:1],
                  pos_row[tbds_pkg::POS_W-1:0],
                  pos_col[tbds_pkg::POS_W-1:0],
                  mean};
      m_tlast <= is_last;
      m_tuser <= opaque;
    end
  end

`ifndef NO_ASSERTIONS
  a_opaque_only_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("quadrant_opaque set on a result that does not end the tile");

  a_last_alpha_opaque: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && (m_tdata[63:48] != '0) |-> m_tuser)
    else $error("last result with nonzero alpha not reported opaque");

  a_block_makes_result: assert property (@(posedge clk) disable iff (rst)
    make_result |=> m_tvalid)
    else $error("closing pixel of a 2x2 block produced no result");

  a_counter_in_tile: assert property (@(posedge clk) disable iff (rst)
    {1'b0, column_count} < (CNT_W+1)'(tbds_pkg::TILE_SIZE))
    else $error("column counter left the tile");
`endif

endmodule
